>>> src/mjs_pkg.sv
// Shared types, codes and record helpers of the multicore job scheduler.
package mjs_pkg;

   localparam int MAX_CORES_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 64;

   typedef enum logic [1:0] {
      OP_NEW    = 2'd0,
      OP_FINISH = 2'd1,
      OP_EXPIRE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SCH_FCFS = 3'd0,
      SCH_SJF  = 3'd1,
      SCH_PSJF = 3'd2,
      SCH_PRI  = 3'd3,
      SCH_PPRI = 3'd4,
      SCH_RR   = 3'd5
   } scheme_type;

   localparam logic [0:0] REG_SCHEME = 1'b0;
   localparam logic [0:0] REG_CORES  = 1'b1;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] arrival;
      logic [15:0] prio;
      logic [31:0] orig;
      logic [31:0] remain;
      logic [31:0] resp;
      logic [31:0] last;
      logic        resp_ok;
   } rec_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start_idle;
      logic scan_init;
      logic scan_step;
      logic take_victim;
      logic finish;
      logic head_rd;
      logic pop_start;
      logic load_cur;
      logic exp_keep;
      logic set_ovf;
      logic find_init;
      logic find_rd;
      logic find_next;
      logic shift_init;
      logic shift_rd;
      logic shift_wr;
      logic put;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   preempt_scheme;
      logic   core_ok;
      logic   core_busy;
      logic   idle_found;
      logic   q_empty;
      logic   q_full;
      logic   scan_last;
      logic   pre_win;
      logic   ins_ahead;
      logic   find_end;
      logic   shift_done;
   } status_type;

   function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] t);
      return (now >= t) ? now - t : 32'd0;
   endfunction

   function automatic rec_type age(input rec_type r, input logic [31:0] now);
      logic [31:0] el;
      el = since(now, r.last);
      r.remain = (r.remain > el) ? r.remain - el : 32'd0;
      r.last = now;
      return r;
   endfunction

   function automatic rec_type stamp(input rec_type r, input logic [31:0] now);
      if (!r.resp_ok) begin
         r.resp = since(now, r.arrival);
         r.resp_ok = 1'b1;
      end
      r.last = now;
      return r;
   endfunction

   function automatic rec_type clear_fresh(input rec_type r, input logic [31:0] now);
      if (r.resp_ok && (r.resp == since(now, r.arrival))) begin
         r.resp_ok = 1'b0;
      end
      return r;
   endfunction

   // a strictly ahead of b
   function automatic logic ahead(input scheme_type s, input rec_type a, input rec_type b);
      logic res;
      res = 1'b0;
      case (s) inside
         SCH_SJF, SCH_PSJF: res = a.remain < b.remain;
         SCH_PRI, SCH_PPRI: res = (a.prio < b.prio) ||
                                  ((a.prio == b.prio) && (a.arrival < b.arrival));
         default: res = 1'b0;
      endcase
      return res;
   endfunction

   function automatic logic [47:0] add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + 49'(b);
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

endpackage

>>> src/mjs_ctrl.sv
// Sequencer of the multicore job scheduler.
module mjs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   input  mjs_pkg::status_type st,
   output mjs_pkg::cmd_type    cmd
);
   import mjs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DECIDE,
      ST_INS_CHECK,
      ST_POP,
      ST_KEEP,
      ST_EXP_CHK,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (st.op)
               OP_NEW: begin
                  if (st.idle_found) begin
                     cmd.start_idle = 1'b1;
                     state_in = ST_DONE;
                  end else if (st.preempt_scheme) begin
                     cmd.scan_init = 1'b1;
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_INS_CHECK;
                  end
               end
               OP_FINISH: begin
                  state_in = ST_DONE;
                  if (st.core_ok && st.core_busy) begin
                     cmd.finish = 1'b1;
                     if (!st.q_empty) begin
                        cmd.head_rd = 1'b1;
                        state_in = ST_POP;
                     end
                  end
               end
               OP_EXPIRE: begin
                  state_in = ST_DONE;
                  if (st.core_ok && st.core_busy) begin
                     cmd.load_cur = 1'b1;
                     if (st.q_empty) begin
                        state_in = ST_KEEP;
                     end else begin
                        cmd.head_rd = 1'b1;
                        state_in = ST_EXP_CHK;
                     end
                  end else if (st.core_ok && !st.q_empty) begin
                     cmd.head_rd = 1'b1;
                     state_in = ST_POP;
                  end
               end
               OP_NONE: state_in = ST_DONE;
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (st.pre_win) begin
               cmd.take_victim = 1'b1;
               cmd.find_init = 1'b1;
               state_in = ST_FIND_RD;
            end else begin
               state_in = ST_INS_CHECK;
            end
         end
         ST_INS_CHECK: begin
            if (st.q_full) begin
               cmd.set_ovf = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.find_init = 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_POP: begin
            cmd.pop_start = 1'b1;
            state_in = ST_DONE;
         end
         ST_KEEP: begin
            cmd.exp_keep = 1'b1;
            state_in = ST_DONE;
         end
         ST_EXP_CHK: begin
            if (!st.ins_ahead) begin
               cmd.pop_start = 1'b1;
               cmd.find_init = 1'b1;
               state_in = ST_FIND_RD;
            end else begin
               cmd.exp_keep = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_FIND_RD: begin
            if (st.find_end) begin
               cmd.shift_init = 1'b1;
               state_in = ST_SHIFT_RD;
            end else begin
               cmd.find_rd = 1'b1;
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (st.ins_ahead) begin
               cmd.shift_init = 1'b1;
               state_in = ST_SHIFT_RD;
            end else begin
               cmd.find_next = 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (st.shift_done) begin
               cmd.put = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == ST_DONE);
         if (cmd.load) begin
            busy_ff <= 1'b1;
         end else if (state_ff == ST_DONE) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;

   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy_ff) else $error("idle while busy");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (state_ff == ST_DISPATCH)) else $error("accept lost");
   a_valid_after_done: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (!busy_ff && $past(state_ff == ST_DONE))) else $error("stray result");

endmodule

>>> src/mjs_dpath.sv
// Datapath of the multicore job scheduler: core records, ready queue memory, totals.
module mjs_dpath #(
   parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
   parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mjs_pkg::cmd_type    cmd,
   output mjs_pkg::status_type st,
   input  logic [1:0]          req_opcode,
   input  logic [15:0]         req_job_id,
   input  logic [31:0]         req_now,
   input  logic [31:0]         req_run_length,
   input  logic [15:0]         req_job_priority,
   input  logic [2:0]          req_core_index,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [3:0]          csr_wdata,
   output logic                rsp_scheduled,
   output logic [2:0]          rsp_target_core,
   output logic [15:0]         rsp_next_job,
   output logic                rsp_queue_overflow,
   output logic [47:0]         rsp_sum_waiting,
   output logic [47:0]         rsp_sum_turnaround,
   output logic [47:0]         rsp_sum_response,
   output logic [15:0]         rsp_finished_count
);
   import mjs_pkg::*;

   localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int NW = $clog2(MAX_CORES + 1);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic [2:0]    scheme_ff;
   logic [3:0]    cores_cfg_ff;
   scheme_type    sch;
   logic [NW-1:0] ncores;

   rec_type       crec_ff [MAX_CORES];
   logic          busy_ff [MAX_CORES];
   rec_type       mem [QUEUE_DEPTH];
   rec_type       rdata_ff;

   op_type        op_ff;
   logic [31:0]   now_ff;
   logic [2:0]    core_ff;
   rec_type       run_ff;
   rec_type       ins_ff;

   logic [LW-1:0] qcount_ff;
   logic [AW-1:0] hd_ff;
   logic [LW-1:0] idx_ff;
   logic [LW-1:0] pos_ff;
   logic [CW-1:0] sidx_ff;
   logic [CW-1:0] best_ff;
   logic [31:0]   best_remain_ff;
   logic [15:0]   best_prio_ff;
   logic [31:0]   best_arr_ff;

   logic          sched_ff;
   logic [CW-1:0] tcore_ff;
   logic [15:0]   nxt_ff;
   logic          ovf_ff;
   logic [47:0]   tot_wait_ff;
   logic [47:0]   tot_turn_ff;
   logic [47:0]   tot_resp_ff;
   logic [15:0]   done_cnt_ff;

   logic [CW-1:0] cidx;
   logic          core_ok;
   logic [CW-1:0] caddr;
   rec_type       crec_rd;
   rec_type       aged_rd;
   logic          idle_found;
   logic [CW-1:0] idle_idx;
   logic          psjf;
   logic          ppri;
   logic          take;
   logic          q_full;
   logic [LW-1:0] lidx_rd;
   logic [LW:0]   sum_rd;
   logic [LW:0]   sum_wr;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic          cw_en;
   logic          cw_start;
   logic [CW-1:0] cw_addr;
   rec_type       cw_data;
   logic [31:0]   ta;
   logic [31:0]   wt;
   rec_type       new_rec;

   // effective configuration
   always_comb begin
      sch = (scheme_ff <= 3'(SCH_RR)) ? scheme_type'(scheme_ff) : SCH_FCFS;
      if (cores_cfg_ff == 4'd0) begin
         ncores = NW'(1);
      end else if (int'(cores_cfg_ff) > MAX_CORES) begin
         ncores = NW'(MAX_CORES);
      end else begin
         ncores = NW'(cores_cfg_ff);
      end
   end

   assign psjf = (sch == SCH_PSJF);
   assign ppri = (sch == SCH_PPRI);
   assign cidx = CW'(core_ff);
   assign core_ok = int'(core_ff) < int'(ncores);
   assign q_full = (qcount_ff == LW'(QUEUE_DEPTH));

   always_comb begin
      idle_found = 1'b0;
      idle_idx = '0;
      for (int i = MAX_CORES - 1; i >= 0; i--) begin
         if ((i < int'(ncores)) && !busy_ff[i]) begin
            idle_found = 1'b1;
            idle_idx = CW'(i);
         end
      end
   end

   // core record read port
   always_comb begin
      if (cmd.scan_step) begin
         caddr = sidx_ff;
      end else if (cmd.take_victim) begin
         caddr = best_ff;
      end else begin
         caddr = cidx;
      end
   end
   assign crec_rd = crec_ff[caddr];
   assign aged_rd = age(crec_rd, now_ff);

   always_comb begin
      if (sidx_ff == '0) begin
         take = 1'b1;
      end else if (psjf) begin
         take = aged_rd.remain > best_remain_ff;
      end else begin
         take = (crec_rd.prio > best_prio_ff) ||
                ((crec_rd.prio == best_prio_ff) && (crec_rd.arrival > best_arr_ff));
      end
   end

   // core record write port
   always_comb begin
      cw_en = 1'b1;
      cw_start = 1'b1;
      cw_addr = cidx;
      cw_data = stamp(ins_ff, now_ff);
      if (cmd.start_idle) begin
         cw_addr = idle_idx;
         cw_data = stamp(run_ff, now_ff);
      end else if (cmd.take_victim) begin
         cw_addr = best_ff;
         cw_data = stamp(run_ff, now_ff);
      end else if (cmd.pop_start) begin
         cw_data = stamp(rdata_ff, now_ff);
      end else if (cmd.exp_keep) begin
         cw_data = stamp(ins_ff, now_ff);
      end else if (cmd.scan_step && psjf) begin
         cw_start = 1'b0;
         cw_addr = sidx_ff;
         cw_data = aged_rd;
      end else begin
         cw_en = 1'b0;
         cw_start = 1'b0;
      end
   end

   // queue addresses: logical index offset from the head, wrapped
   always_comb begin
      if (cmd.head_rd) begin
         lidx_rd = '0;
      end else if (cmd.find_rd) begin
         lidx_rd = idx_ff;
      end else begin
         lidx_rd = idx_ff - LW'(1);
      end
      sum_rd = (LW+1)'(hd_ff) + (LW+1)'(lidx_rd);
      sum_wr = (LW+1)'(hd_ff) + (LW+1)'(idx_ff);
      raddr = (sum_rd >= (LW+1)'(QUEUE_DEPTH)) ? AW'(sum_rd - (LW+1)'(QUEUE_DEPTH))
                                                : AW'(sum_rd);
      waddr = (sum_wr >= (LW+1)'(QUEUE_DEPTH)) ? AW'(sum_wr - (LW+1)'(QUEUE_DEPTH))
                                                : AW'(sum_wr);
   end

   assign ta = since(now_ff, crec_rd.arrival);
   assign wt = (ta > crec_rd.orig) ? ta - crec_rd.orig : 32'd0;

   always_comb begin
      new_rec.id = req_job_id;
      new_rec.arrival = req_now;
      new_rec.prio = req_job_priority;
      new_rec.orig = req_run_length;
      new_rec.remain = req_run_length;
      new_rec.resp = 32'd0;
      new_rec.last = req_now;
      new_rec.resp_ok = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= 3'(SCH_FCFS);
         cores_cfg_ff <= 4'd1;
         qcount_ff <= '0;
         hd_ff <= '0;
         tot_wait_ff <= '0;
         tot_turn_ff <= '0;
         tot_resp_ff <= '0;
         done_cnt_ff <= '0;
         for (int i = 0; i < MAX_CORES; i++) begin
            busy_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_SCHEME: scheme_ff <= csr_wdata[2:0];
               REG_CORES:  cores_cfg_ff <= csr_wdata;
               default:    ;
            endcase
         end
         if (cw_start) begin
            busy_ff[cw_addr] <= 1'b1;
         end else if (cmd.finish) begin
            busy_ff[cidx] <= 1'b0;
         end
         if (cmd.finish) begin
            tot_wait_ff <= add48(tot_wait_ff, wt);
            tot_turn_ff <= add48(tot_turn_ff, ta);
            tot_resp_ff <= add48(tot_resp_ff, crec_rd.resp_ok ? crec_rd.resp : 32'd0);
            if (done_cnt_ff != 16'hFFFF) begin
               done_cnt_ff <= done_cnt_ff + 16'd1;
            end
         end
         if (cmd.pop_start) begin
            hd_ff <= (hd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : hd_ff + AW'(1);
            qcount_ff <= qcount_ff - LW'(1);
         end else if (cmd.put) begin
            qcount_ff <= qcount_ff + LW'(1);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cw_en) begin
         crec_ff[cw_addr] <= cw_data;
      end
      if (cmd.load) begin
         op_ff <= op_type'(req_opcode);
         now_ff <= req_now;
         core_ff <= req_core_index;
         run_ff <= new_rec;
         ins_ff <= new_rec;
         sched_ff <= 1'b0;
         tcore_ff <= '0;
         nxt_ff <= '0;
         ovf_ff <= 1'b0;
      end
      if (cmd.load_cur) begin
         ins_ff <= aged_rd;
      end
      if (cmd.take_victim) begin
         ins_ff <= clear_fresh(crec_rd, now_ff);
      end
      if (cmd.start_idle || cmd.take_victim || cmd.pop_start || cmd.exp_keep) begin
         sched_ff <= 1'b1;
         tcore_ff <= cw_addr;
      end
      if (cmd.pop_start) begin
         nxt_ff <= rdata_ff.id;
      end
      if (cmd.exp_keep) begin
         nxt_ff <= ins_ff.id;
      end
      if (cmd.set_ovf) begin
         ovf_ff <= 1'b1;
      end
      if (cmd.scan_init) begin
         sidx_ff <= '0;
      end
      if (cmd.scan_step) begin
         sidx_ff <= sidx_ff + CW'(1);
         if (take) begin
            best_ff <= sidx_ff;
            best_remain_ff <= aged_rd.remain;
            best_prio_ff <= crec_rd.prio;
            best_arr_ff <= crec_rd.arrival;
         end
      end
      if (cmd.find_init) begin
         idx_ff <= '0;
      end
      if (cmd.find_next) begin
         idx_ff <= idx_ff + LW'(1);
      end
      if (cmd.shift_init) begin
         pos_ff <= idx_ff;
         idx_ff <= qcount_ff;
      end
      if (cmd.shift_wr) begin
         idx_ff <= idx_ff - LW'(1);
      end
   end

   // ready queue memory
   always_ff @(posedge clock) begin
      if (cmd.head_rd || cmd.find_rd || cmd.shift_rd) begin
         rdata_ff <= mem[raddr];
      end
      if (cmd.shift_wr) begin
         mem[waddr] <= rdata_ff;
      end else if (cmd.put) begin
         mem[waddr] <= ins_ff;
      end
   end

   always_comb begin
      st.op = op_ff;
      st.preempt_scheme = psjf || ppri;
      st.core_ok = core_ok;
      st.core_busy = busy_ff[cidx];
      st.idle_found = idle_found;
      st.q_empty = (qcount_ff == '0);
      st.q_full = q_full;
      st.scan_last = (int'(sidx_ff) == int'(ncores) - 1);
      st.pre_win = !q_full && (psjf ? (best_remain_ff > run_ff.orig)
                                    : (best_prio_ff > run_ff.prio));
      st.ins_ahead = ahead(sch, ins_ff, rdata_ff);
      st.find_end = (idx_ff == qcount_ff);
      st.shift_done = (idx_ff == pos_ff);
   end

   assign rsp_scheduled = sched_ff;
   assign rsp_target_core = 3'(tcore_ff);
   assign rsp_next_job = nxt_ff;
   assign rsp_queue_overflow = ovf_ff;
   assign rsp_sum_waiting = tot_wait_ff;
   assign rsp_sum_turnaround = tot_turn_ff;
   assign rsp_sum_response = tot_resp_ff;
   assign rsp_finished_count = done_cnt_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= LW'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !q_full) else $error("insert into full queue");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_start |-> (qcount_ff != '0)) else $error("pop from empty queue");

endmodule

>>> src/multicore_job_scheduler_unit.sv
// Top level of the multicore job scheduler.
// Usage: pulse start with the req_ fields while busy is low; the event is taken
// at that edge and busy rises for the duration of the work. Opcodes: new job,
// job finished on req_core_index, quantum expired on req_core_index.
// Exactly one result per event, shown on the rsp_ ports for one cycle with
// rsp_valid high; the receiver takes it that cycle and cannot stall it.
// A job placed on an idle core, a finish without a pop, an ignored event,
// a pop of the queue head and an expiry that keeps its job need no queue
// walk. A queue insert walks the ready queue memory (one read port,
// registered data): it reads each entry ahead of the slot, then moves each
// entry behind it one place. Preemptive schemes first scan the record of
// each core in use. A new event is taken the cycle rsp_valid is high.
// csr_we writes scheme (index 0) or core count (index 1); the user must write
// only while idle, and the block itself does not enforce it.
// Reset (synchronous): all cores idle, queue empty, totals zero, scheme FCFS,
// one core in use.
module multicore_job_scheduler_unit #(
   parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
   parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_job_id,
   input  logic [31:0] req_now,
   input  logic [31:0] req_run_length,
   input  logic [15:0] req_job_priority,
   input  logic [2:0]  req_core_index,
   output logic        rsp_valid,
   output logic        rsp_scheduled,
   output logic [2:0]  rsp_target_core,
   output logic [15:0] rsp_next_job,
   output logic        rsp_queue_overflow,
   output logic [47:0] rsp_sum_waiting,
   output logic [47:0] rsp_sum_turnaround,
   output logic [47:0] rsp_sum_response,
   output logic [15:0] rsp_finished_count,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import mjs_pkg::*;

   cmd_type    cmd;
   status_type st;

   mjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .st        (st),
      .cmd       (cmd)
   );

   mjs_dpath #(
      .MAX_CORES   (MAX_CORES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_opcode         (req_opcode),
      .req_job_id         (req_job_id),
      .req_now            (req_now),
      .req_run_length     (req_run_length),
      .req_job_priority   (req_job_priority),
      .req_core_index     (req_core_index),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_scheduled      (rsp_scheduled),
      .rsp_target_core    (rsp_target_core),
      .rsp_next_job       (rsp_next_job),
      .rsp_queue_overflow (rsp_queue_overflow),
      .rsp_sum_waiting    (rsp_sum_waiting),
      .rsp_sum_turnaround (rsp_sum_turnaround),
      .rsp_sum_response   (rsp_sum_response),
      .rsp_finished_count (rsp_finished_count)
   );

endmodule
